// ===== hdl/firsat_pkg.sv =====
// Shared types, constants and coefficient table for the saturating FIR filter.
// No dependencies.

package firsat_pkg;

    localparam int DEF_TAP_COUNT = 256;
    localparam int DEF_ACC_BITS  = 48;

    localparam int DATA_W     = 16;
    localparam int PROD_W     = 32;
    localparam int ROM_DEPTH  = 256;
    localparam int TAP_IDX_W  = 10;
    localparam int SAT_MSB    = 30;
    localparam int OUT_LSB    = 15;

    localparam logic signed [DATA_W-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] OUT_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } fir_state_t;

    typedef logic signed [DATA_W-1:0] sample_t;

    localparam sample_t COEF_ROM [ROM_DEPTH] = '{
        -16'sd3, -16'sd8, -16'sd8, -16'sd12, -16'sd13, -16'sd13, -16'sd12, -16'sd9,
        -16'sd4, 16'sd1, 16'sd6, 16'sd10, 16'sd11, 16'sd9, 16'sd5, 16'sd0,
        -16'sd6, -16'sd11, -16'sd13, -16'sd13, -16'sd9, -16'sd2, 16'sd6, 16'sd13,
        16'sd17, 16'sd17, 16'sd13, 16'sd5, -16'sd5, -16'sd14, -16'sd21, -16'sd23,
        -16'sd19, -16'sd10, 16'sd2, 16'sd15, 16'sd25, 16'sd30, 16'sd27, 16'sd17,
        16'sd2, -16'sd15, -16'sd29, -16'sd37, -16'sd36, -16'sd26, -16'sd8, 16'sd13,
        16'sd33, 16'sd45, 16'sd47, 16'sd37, 16'sd17, -16'sd9, -16'sd35, -16'sd53,
        -16'sd59, -16'sd50, -16'sd28, 16'sd3, 16'sd36, 16'sd61, 16'sd73, 16'sd66,
        16'sd43, 16'sd6, -16'sd34, -16'sd69, -16'sd88, -16'sd86, -16'sd61, -16'sd20,
        16'sd30, 16'sd75, 16'sd104, 16'sd108, 16'sd85, 16'sd38, -16'sd22, -16'sd80,
        -16'sd122, -16'sd135, -16'sd114, -16'sd63, 16'sd9, 16'sd83, 16'sd142, 16'sd167,
        16'sd152, 16'sd96, 16'sd11, -16'sd83, -16'sd163, -16'sd207, -16'sd200, -16'sd142,
        -16'sd41, 16'sd78, 16'sd187, 16'sd257, 16'sd266, 16'sd206, 16'sd87, -16'sd66,
        -16'sd217, -16'sd327, -16'sd362, -16'sd306, -16'sd163, 16'sd41, 16'sd259, 16'sd436,
        16'sd522, 16'sd481, 16'sd303, 16'sd14, -16'sd331, -16'sd654, -16'sd866, -16'sd886,
        -16'sd661, -16'sd174, 16'sd543, 16'sd1416, 16'sd2336, 16'sd3176, 16'sd3818, 16'sd4164,
        16'sd4164, 16'sd3818, 16'sd3176, 16'sd2336, 16'sd1416, 16'sd543, -16'sd174, -16'sd661,
        -16'sd886, -16'sd866, -16'sd654, -16'sd331, 16'sd14, 16'sd303, 16'sd481, 16'sd522,
        16'sd436, 16'sd259, 16'sd41, -16'sd163, -16'sd306, -16'sd362, -16'sd327, -16'sd217,
        -16'sd66, 16'sd87, 16'sd206, 16'sd266, 16'sd257, 16'sd187, 16'sd78, -16'sd41,
        -16'sd142, -16'sd200, -16'sd207, -16'sd163, -16'sd83, 16'sd11, 16'sd96, 16'sd152,
        16'sd167, 16'sd142, 16'sd83, 16'sd9, -16'sd63, -16'sd114, -16'sd135, -16'sd122,
        -16'sd80, -16'sd22, 16'sd38, 16'sd85, 16'sd108, 16'sd104, 16'sd75, 16'sd30,
        -16'sd20, -16'sd61, -16'sd86, -16'sd88, -16'sd69, -16'sd34, 16'sd6, 16'sd43,
        16'sd66, 16'sd73, 16'sd61, 16'sd36, 16'sd3, -16'sd28, -16'sd50, -16'sd59,
        -16'sd53, -16'sd35, -16'sd9, 16'sd17, 16'sd37, 16'sd47, 16'sd45, 16'sd33,
        16'sd13, -16'sd8, -16'sd26, -16'sd36, -16'sd37, -16'sd29, -16'sd15, 16'sd2,
        16'sd17, 16'sd27, 16'sd30, 16'sd25, 16'sd15, 16'sd2, -16'sd10, -16'sd19,
        -16'sd23, -16'sd21, -16'sd14, -16'sd5, 16'sd5, 16'sd13, 16'sd17, 16'sd17,
        16'sd13, 16'sd6, -16'sd2, -16'sd9, -16'sd13, -16'sd13, -16'sd11, -16'sd6,
        16'sd0, 16'sd5, 16'sd9, 16'sd11, 16'sd10, 16'sd6, 16'sd1, -16'sd4,
        -16'sd9, -16'sd12, -16'sd13, -16'sd13, -16'sd12, -16'sd8, -16'sd8, -16'sd3
    };

    function automatic sample_t coef_at(logic [TAP_IDX_W-1:0] idx);
        sample_t c;
        if (idx < TAP_IDX_W'(ROM_DEPTH))
        begin
            c = COEF_ROM[idx[7:0]];
        end
        else
        begin
            c = '0;
        end
        return c;
    endfunction

endpackage

// ===== hdl/fir_filter_saturating.sv =====
// Top level of the saturating FIR filter: history memory, MAC pipeline, output register.
// Depends on firsat_pkg.
//
// Usage:
//   Input channel  sample_in / in_valid / in_stall: one signed 16-bit sample per beat.
//   Output channel filtered_out, clipped / out_valid / out_stall: one result per beat.
//   Every input beat yields exactly one output beat, in order.
//   The sample history sits in a single-port-read synchronous memory of TAP_COUNT
//   entries; one tap is read and multiplied per cycle, so the MAC loop over the
//   taps sets the rate.
//   in_stall is high from the input beat until the result enters the output
//   register; that register frees the filter while the result waits.
//   If out_stall holds the previous result, the finished sum waits in the
//   accumulator and in_stall stays high.
//   Reset empties the pipeline and output register; the history reads as zero
//   until each entry has been written once, with no clearing pass.
//   Sums outside [-2^30, 2^30-1] clamp and raise clipped.

module fir_filter_saturating
    import firsat_pkg::*;
#(
    parameter int TAP_COUNT = DEF_TAP_COUNT,
    parameter int ACC_BITS  = DEF_ACC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [DATA_W-1:0] sample_in,
    input  logic                     in_valid,
    output logic                     in_stall,
    output logic signed [DATA_W-1:0] filtered_out,
    output logic                     clipped,
    output logic                     out_valid,
    input  logic                     out_stall
);

    localparam int KW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam logic [KW-1:0] LAST_IDX = KW'(TAP_COUNT - 1);

    fir_state_t state_reg, state_next;

    sample_t hist_mem [TAP_COUNT];

    logic [KW-1:0]              wr_pos_reg;
    logic [KW-1:0]              cur_pos_reg;
    logic [KW-1:0]              rd_ptr_reg;
    logic [KW-1:0]              k_reg;
    logic                       full_reg;

    logic                       s1_vld_reg;
    logic                       s1_last_reg;
    logic                       s1_ok_reg;
    sample_t                    s1_data_reg;
    sample_t                    s1_coef_reg;

    logic                       s2_vld_reg;
    logic                       s2_last_reg;
    logic signed [PROD_W-1:0]   s2_prod_reg;

    logic signed [ACC_BITS-1:0] acc_reg;

    logic                       out_valid_reg;
    sample_t                    out_data_reg;
    logic                       out_clip_reg;

    logic                       accept;
    logic                       issue_en;
    logic                       load_out;
    logic                       sat;
    sample_t                    sat_value;

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (k_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (s2_vld_reg && s2_last_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        issue_en = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_ISSUE:
            begin
                issue_en = 1'b1;
            end
            ST_DRAIN:
            begin
                issue_en = 1'b0;
            end
            ST_DONE:
            begin
                load_out = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // history memory: write on the input beat, one tap read per cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_mem[wr_pos_reg] <= sample_in;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_data_reg <= hist_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg <= '0;
            full_reg   <= 1'b0;
        end
        else if (accept)
        begin
            wr_pos_reg <= (wr_pos_reg == LAST_IDX) ? '0 : wr_pos_reg + 1'b1;
            full_reg   <= full_reg || (wr_pos_reg == LAST_IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pos_reg <= '0;
            rd_ptr_reg  <= '0;
            k_reg       <= '0;
        end
        else if (accept)
        begin
            cur_pos_reg <= wr_pos_reg;
            rd_ptr_reg  <= wr_pos_reg;
            k_reg       <= '0;
        end
        else if (issue_en)
        begin
            rd_ptr_reg <= (rd_ptr_reg == '0) ? LAST_IDX : rd_ptr_reg - 1'b1;
            k_reg      <= k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= issue_en;
            s1_last_reg <= issue_en && (k_reg == LAST_IDX);
            s2_vld_reg  <= s1_vld_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // entries not yet written since reset read as zero
    always_ff @(posedge clk)
    begin
        s1_coef_reg <= coef_at(TAP_IDX_W'(k_reg));
        s1_ok_reg   <= full_reg || (rd_ptr_reg <= cur_pos_reg);
        s2_prod_reg <= s1_ok_reg ? PROD_W'(s1_data_reg * s1_coef_reg) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            acc_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_BITS-PROD_W){s2_prod_reg[PROD_W-1]}}, s2_prod_reg};
        end
    end

    assign sat       = !((&acc_reg[ACC_BITS-1:SAT_MSB]) || !(|acc_reg[ACC_BITS-1:SAT_MSB]));
    assign sat_value = acc_reg[ACC_BITS-1] ? OUT_MIN : OUT_MAX;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= sat ? sat_value : acc_reg[SAT_MSB:OUT_LSB];
            out_clip_reg <= sat;
        end
    end

    assign out_valid    = out_valid_reg;
    assign filtered_out = out_data_reg;
    assign clipped      = out_clip_reg;

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !s1_vld_reg && !s2_vld_reg)
        else $error("input ready while MAC pipeline busy");

    a_accept_locks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("second beat accepted during filter run");

    a_last_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg && s2_last_reg |=> state_reg == ST_DONE)
        else $error("final product did not close the sum");

    a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> filtered_out == OUT_MAX || filtered_out == OUT_MIN)
        else $error("clipped result not at a limit");

endmodule

// ===== verif/fir_sat_checker.sv =====
// Result checker for the saturating FIR filter: watches both channels, keeps its own
// copy of the sample history to predict each beat, and counts mismatches.
// Depends on firsat_pkg for the sample type, the coefficient table and the clamp limits.

module fir_sat_checker
    import firsat_pkg::*;
#(
    parameter int TAP_COUNT = DEF_TAP_COUNT,
    parameter int ACC_BITS  = DEF_ACC_BITS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  sample_t sample_in,
    input  logic    in_valid,
    input  logic    in_stall,
    input  sample_t filtered_out,
    input  logic    clipped,
    input  logic    out_valid,
    input  logic    out_stall,
    output int      errors,
    output int      awaiting,
    output int      checked,
    output int      clip_hi,
    output int      clip_lo
);

    typedef struct packed {
        sample_t value;
        logic    clip;
    } filt_result_t;

    localparam longint SAT_HI = (64'sd1 <<< SAT_MSB) - 64'sd1;
    localparam longint SAT_LO = -(64'sd1 <<< SAT_MSB);

    sample_t      history [TAP_COUNT];
    int           head;
    filt_result_t expected_q [$];
    filt_result_t want;
    int           bad;

    function automatic filt_result_t filter_step(sample_t x);
        longint       acc;
        filt_result_t r;
        history[head] = x;
        acc = 0;
        for (int k = 0; k < TAP_COUNT; k++)
        begin
            if (k < ROM_DEPTH)
            begin
                acc += longint'(history[(head + TAP_COUNT - k) % TAP_COUNT])
                       * longint'(COEF_ROM[k]);
            end
        end
        head = (head + 1) % TAP_COUNT;
        acc = (acc <<< (64 - ACC_BITS)) >>> (64 - ACC_BITS);
        r.clip = (acc > SAT_HI) || (acc < SAT_LO);
        if (acc > SAT_HI)
        begin
            acc = SAT_HI;
        end
        else if (acc < SAT_LO)
        begin
            acc = SAT_LO;
        end
        r.value = sample_t'(acc >>> OUT_LSB);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAP_COUNT; i++)
            begin
                history[i] = '0;
            end
            head = 0;
            expected_q.delete();
            errors   <= 0;
            awaiting <= 0;
            checked  <= 0;
            clip_hi  <= 0;
            clip_lo  <= 0;
        end
        else
        begin
            bad = 0;
            if (in_valid && !in_stall)
            begin
                expected_q.push_back(filter_step(sample_in));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with nothing pending: filtered_out=%0d clipped=%0b",
                           filtered_out, clipped);
                    bad++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    checked <= checked + 1;
                    if (filtered_out !== want.value)
                    begin
                        $error("filtered_out: expected %0d, got %0d", want.value, filtered_out);
                        bad++;
                    end
                    if (clipped !== want.clip)
                    begin
                        $error("clipped: expected %0b, got %0b", want.clip, clipped);
                        bad++;
                    end
                    if (want.clip && want.value[DATA_W-1])
                    begin
                        clip_lo <= clip_lo + 1;
                    end
                    else if (want.clip)
                    begin
                        clip_hi <= clip_hi + 1;
                    end
                end
            end
            errors   <= errors + bad;
            awaiting <= expected_q.size();
        end
    end

endmodule

// ===== verif/fir_filter_saturating_test.sv =====
// Top of the saturating FIR filter testbench: clock, reset, sample stimulus and
// random output back-pressure, with the verdict taken from fir_sat_checker.
// Depends on firsat_pkg, fir_filter_saturating and fir_sat_checker.

module fir_filter_saturating_test;
    import firsat_pkg::*;

    localparam int TAP_COUNT = DEF_TAP_COUNT;
    localparam int ACC_BITS  = DEF_ACC_BITS;
    localparam int ITEMS     = 1250;

    localparam sample_t CORNER_SAMPLES [15] = '{
        16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh8000,
        16'sh8000, 16'sh0001, 16'shFFFF, 16'sh5555, 16'shAAAA,
        16'sh7FFE, 16'sh8001, 16'sh00FF, 16'shFF00, 16'sh0000
    };

    logic    clk;
    logic    rst_n;
    sample_t sample_in;
    logic    in_valid;
    logic    in_stall;
    sample_t filtered_out;
    logic    clipped;
    logic    out_valid;
    logic    out_stall;

    int errors;
    int awaiting;
    int checked;
    int clip_hi;
    int clip_lo;
    int sent;
    bit steady;

    fir_filter_saturating #(.TAP_COUNT(TAP_COUNT), .ACC_BITS(ACC_BITS)) dut (.*);

    fir_sat_checker #(.TAP_COUNT(TAP_COUNT), .ACC_BITS(ACC_BITS)) checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #9000000;
        $display("FAIL");
        $finish;
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 4);
        end
        if (r < 97)
        begin
            return $urandom_range(5, 40);
        end
        return $urandom_range(41, 300);
    endfunction

    task automatic send(sample_t x);
        int gap;
        if (sent >= ITEMS)
        begin
            return;
        end
        gap = steady ? 0 : pick_idle();
        in_valid  <= 1'b1;
        sample_in <= x;
        do @(posedge clk); while (in_stall);
        sent++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0) @(posedge clk);
    endtask

    // Sample i has the sign of COEF_ROM[i], inverted by flip; full runs match the last beat.
    task automatic matched_run(int len, bit flip);
        sample_t x;
        for (int i = 0; i < len; i++)
        begin
            if (COEF_ROM[i % ROM_DEPTH] == 0)
            begin
                x = sample_t'($urandom_range(0, 65535));
            end
            else if ((COEF_ROM[i % ROM_DEPTH] < 0) ^ flip)
            begin
                x = sample_t'(-$urandom_range(26000, 32768));
            end
            else
            begin
                x = sample_t'($urandom_range(26000, 32767));
            end
            send(x);
        end
    endtask

    initial
    begin
        int      r;
        int      quiet;
        out_stall = 1'b0;
        forever
        begin
            r = $urandom_range(0, 19);
            quiet = (r == 0) ? $urandom_range(200, 2000) : 1 + pick_idle();
            repeat (quiet) @(posedge clk);
            out_stall <= 1'b1;
            repeat (1 + pick_idle()) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        sample_t level;
        int      len;
        int      r;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        sample_in = '0;
        steady    = 1'b0;
        sent      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (CORNER_SAMPLES[i])
        begin
            send(CORNER_SAMPLES[i]);
        end
        drain();

        while (sent < ITEMS)
        begin
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    matched_run(TAP_COUNT, $urandom_range(0, 1) == 1);
                end
                3:
                begin
                    matched_run($urandom_range(20, TAP_COUNT - 1), $urandom_range(0, 1) == 1);
                end
                4, 5:
                begin
                    repeat ($urandom_range(1, 40)) send(sample_t'($urandom));
                end
                6:
                begin
                    r = $urandom_range(0, 2);
                    level = (r == 0) ? OUT_MAX : (r == 1) ? OUT_MIN : sample_t'($urandom);
                    repeat ($urandom_range(20, 300)) send(level);
                end
                7:
                begin
                    send($urandom_range(0, 1) ? OUT_MAX : OUT_MIN);
                    repeat ($urandom_range(1, 30)) send('0);
                end
                8:
                begin
                    len = $urandom_range(20, 100);
                    for (int i = 0; i < len; i++)
                    begin
                        send((i % 2) ? OUT_MAX : OUT_MIN);
                    end
                end
                default:
                begin
                    drain();
                end
            endcase
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0) @(posedge clk);
        repeat (TAP_COUNT + 8) @(posedge clk);

        $display("Drove %0d samples: corner values, coefficient-matched runs, DC, square waves,",
                 sent);
        $display("impulses and noise; %0d results compared, %0d clamped high, %0d clamped low.",
                 checked, clip_hi, clip_lo);
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/firsat_pkg.sv
hdl/fir_filter_saturating.sv
verif/fir_sat_checker.sv
verif/fir_filter_saturating_test.sv
